@@ src/lscm_pkg.sv @@
// Shared types, constants and the table index fold for the logical sector to CHS mapper.
package lscm_pkg;

   // Translation table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);

   // Field and register widths
   localparam int TRK_W      = 8;
   localparam int REC_W      = 8;
   localparam int CYL_W      = 8;
   localparam int HEAD_W     = 8;
   localparam int SEC_W      = 8;
   localparam int SUB_W      = 4;
   localparam int TIDX_W     = 6;
   localparam int CYLCNT_W   = 9;
   localparam int SHIFT_W    = 3;
   localparam int ORDER_W    = 2;
   localparam int TEN_W      = 2;
   localparam int CSR_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int MAX_SHIFT  = 4;
   localparam int LUT_DEPTH  = 1 << SEC_W;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRACK_ORDER    = 3'd0,
      CSR_CYLINDER_COUNT = 3'd1,
      CSR_HEAD_COUNT     = 3'd2,
      CSR_RECORD_SHIFT   = 3'd3,
      CSR_SYSTEM_TRACKS  = 3'd4,
      CSR_SW_TRANSLATE   = 3'd5,
      CSR_TABLE_ENABLE   = 3'd6
   } csr_index_type;

   // Track orderings
   typedef enum logic [ORDER_W-1:0] {
      ORDER_CYL_MAJOR   = 2'd0,
      ORDER_HEAD_MAJOR  = 2'd1,
      ORDER_HEAD_MIRROR = 2'd2
   } track_order_type;

   // Request actions
   localparam logic ACTION_MAP  = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   typedef struct packed {
      logic              action;
      logic [TRK_W-1:0]  track;
      logic [REC_W-1:0]  record;
      logic              table_select;
      logic [TIDX_W-1:0] table_index;
      logic [SEC_W-1:0]  table_value;
   } req_type;

   typedef struct packed {
      logic [CYL_W-1:0]  cylinder;
      logic [HEAD_W-1:0] head;
      logic [SEC_W-1:0]  sector;
      logic [SUB_W-1:0]  record_in_sector;
      logic              is_mapping;
   } rsp_type;

   // Fold any 8-bit sector or index onto the table depth
   typedef logic [TBL_AW-1:0] tbl_lut_type [LUT_DEPTH];

   function automatic tbl_lut_type tbl_lut_build();
      tbl_lut_type lut;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = TBL_AW'(i % TABLE_DEPTH);
      end
      return lut;
   endfunction

   localparam tbl_lut_type TBL_MOD_LUT = tbl_lut_build();

endpackage

@@ src/lscm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lscm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lscm_div.sv @@
// Three-stage restoring divider for the track split into cylinder and head.
module lscm_div (
   input  logic                           clock,
   input  logic [lscm_pkg::TRK_W-1:0]     dividend,
   input  logic [lscm_pkg::CYLCNT_W-1:0]  divisor,
   output logic [lscm_pkg::TRK_W-1:0]     quotient,
   output logic [lscm_pkg::TRK_W-1:0]     remainder
);
   import lscm_pkg::*;

   localparam int STEPS_A = 3;
   localparam int STEPS_B = 3;
   localparam int STEPS_C = TRK_W - STEPS_A - STEPS_B;

   typedef struct packed {
      logic [CYLCNT_W-1:0] rem;
      logic [TRK_W-1:0]    num;
      logic [TRK_W-1:0]    quo;
   } div_state_type;

   // One quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic div_state_type div_step(div_state_type s, logic [CYLCNT_W-1:0] den);
      div_state_type       r;
      logic [CYLCNT_W-1:0] part;
      part  = {s.rem[CYLCNT_W-2:0], s.num[TRK_W-1]};
      r.num = {s.num[TRK_W-2:0], 1'b0};
      if (part >= den) begin
         r.rem = part - den;
         r.quo = {s.quo[TRK_W-2:0], 1'b1};
      end else begin
         r.rem = part;
         r.quo = {s.quo[TRK_W-2:0], 1'b0};
      end
      return r;
   endfunction

   div_state_type       st_a_in, st_b_in, st_c_in;
   div_state_type       st_a_ff, st_b_ff, st_c_ff;
   logic [CYLCNT_W-1:0] den_a_ff, den_b_ff;

   // First group of steps from the fresh dividend
   always_comb begin
      st_a_in     = '0;
      st_a_in.num = dividend;
      for (int i = 0; i < STEPS_A; i++) begin
         st_a_in = div_step(st_a_in, divisor);
      end
   end

   // Middle group of steps
   always_comb begin
      st_b_in = st_a_ff;
      for (int i = 0; i < STEPS_B; i++) begin
         st_b_in = div_step(st_b_in, den_a_ff);
      end
   end

   // Last group of steps
   always_comb begin
      st_c_in = st_b_ff;
      for (int i = 0; i < STEPS_C; i++) begin
         st_c_in = div_step(st_c_in, den_b_ff);
      end
   end

   // Advance partial results and divisor every cycle
   always_ff @(posedge clock) begin
      st_a_ff  <= st_a_in;
      den_a_ff <= divisor;
      st_b_ff  <= st_b_in;
      den_b_ff <= den_a_ff;
      st_c_ff  <= st_c_in;
   end

   assign quotient  = st_c_ff.quo;
   assign remainder = st_c_ff.rem[TRK_W-1:0];

endmodule

@@ src/logical_sector_to_chs_mapper_top.sv @@
// Top level of the logical sector to cylinder/head/sector mapper.
//
// One request (map or table load) is taken on every cycle in which start is high and busy
// is low; busy is high only during reset. Each request gives exactly one result on the rsp_
// ports, marked by rsp_valid for one cycle, in request order. The rate of one request a
// cycle is set by a four-stage pipeline: an input stage, then an eight-step restoring
// divider split three, three and two steps over the next stages, with the translation
// tables read in the last of them and the sector choice and cylinder mirroring done into
// the output register. A table load takes effect for every request that follows it. The
// receiver cannot stall the block. Table entries that were never loaded read back as
// undefined; there is no clearing pass.
module logical_sector_to_chs_mapper_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  lscm_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output lscm_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [lscm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lscm_pkg::CSR_W-1:0]     csr_wdata
);
   import lscm_pkg::*;

   localparam int STAGES = 4;

   typedef struct packed {
      logic                is_load;
      logic [TRK_W-1:0]    track;
      logic [CYLCNT_W-1:0] divisor;
      logic [SEC_W-1:0]    sector;
      logic [SUB_W-1:0]    sub;
      logic                sys_ok;
      logic [TBL_AW-1:0]   tbl_addr;
      logic                tbl_sel;
      logic [SEC_W-1:0]    tbl_value;
   } item_type;

   // Configuration registers
   logic [ORDER_W-1:0]  track_order_ff;
   logic [CYLCNT_W-1:0] cyl_count_ff;
   logic [HEAD_W-1:0]   head_count_ff;
   logic [SHIFT_W-1:0]  record_shift_ff;
   logic [TRK_W-1:0]    system_tracks_ff;
   logic                sw_translate_ff;
   logic [TEN_W-1:0]    table_enable_ff;

   // Pipeline
   item_type            item_in;
   item_type            stg_item_ff [STAGES];
   logic                stg_valid_ff [STAGES];
   logic                accept;

   // Derived configuration
   logic [CYLCNT_W-1:0] cyls;
   logic [HEAD_W-1:0]   heads;
   logic                head_major;
   logic [SHIFT_W-1:0]  shift;
   logic [SUB_W-1:0]    sub_mask;

   // Divider and tables
   logic [TRK_W-1:0]    quo;
   logic [TRK_W-1:0]    rem;
   logic                tbl_wr;
   logic [SEC_W-1:0]    even_rd;
   logic [SEC_W-1:0]    odd_rd;

   // Result stage
   logic [CYL_W-1:0]    cyl_raw;
   logic [HEAD_W-1:0]   head_val;
   logic [CYL_W-1:0]    cyl_val;
   logic                odd_head;
   logic                use_table;
   logic [SEC_W-1:0]    sec_val;
   rsp_type             rsp_in;
   rsp_type             rsp_data_ff;
   logic                rsp_valid_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         track_order_ff   <= ORDER_HEAD_MIRROR;
         cyl_count_ff     <= CYLCNT_W'(77);
         head_count_ff    <= HEAD_W'(1);
         record_shift_ff  <= '0;
         system_tracks_ff <= TRK_W'(2);
         sw_translate_ff  <= 1'b0;
         table_enable_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TRACK_ORDER:    track_order_ff   <= csr_wdata[ORDER_W-1:0];
            CSR_CYLINDER_COUNT: cyl_count_ff     <= csr_wdata[CYLCNT_W-1:0];
            CSR_HEAD_COUNT:     head_count_ff    <= csr_wdata[HEAD_W-1:0];
            CSR_RECORD_SHIFT:   record_shift_ff  <= csr_wdata[SHIFT_W-1:0];
            CSR_SYSTEM_TRACKS:  system_tracks_ff <= csr_wdata[TRK_W-1:0];
            CSR_SW_TRANSLATE:   sw_translate_ff  <= csr_wdata[0];
            CSR_TABLE_ENABLE:   table_enable_ff  <= csr_wdata[TEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp counts and shift to their usable ranges
   always_comb begin
      cyls       = (cyl_count_ff == '0) ? CYLCNT_W'(1) : cyl_count_ff;
      heads      = (head_count_ff == '0) ? HEAD_W'(1) : head_count_ff;
      head_major = (track_order_ff == ORDER_HEAD_MAJOR) ||
                   (track_order_ff == ORDER_HEAD_MIRROR);
      shift      = (record_shift_ff > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                             : record_shift_ff;
      sub_mask   = ~({SUB_W{1'b1}} << shift);
   end

   // Input stage: split the record, pick the divisor and the table entry
   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      item_in.is_load   = (req_data.action == ACTION_LOAD);
      item_in.track     = req_data.track;
      item_in.divisor   = head_major ? cyls : {1'b0, heads};
      item_in.sector    = req_data.record >> shift;
      item_in.sub       = req_data.record[SUB_W-1:0] & sub_mask;
      item_in.sys_ok    = (req_data.track >= system_tracks_ff);
      item_in.tbl_sel   = req_data.table_select;
      item_in.tbl_value = req_data.table_value;
      if (item_in.is_load) begin
         item_in.tbl_addr = TBL_MOD_LUT[SEC_W'(req_data.table_index)];
      end else begin
         item_in.tbl_addr = TBL_MOD_LUT[item_in.sector];
      end
   end

   // Advance the pipeline every cycle; valid bits travel with the items
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            stg_valid_ff[i] <= 1'b0;
         end
      end else begin
         stg_valid_ff[0] <= accept;
         for (int i = 1; i < STAGES; i++) begin
            stg_valid_ff[i] <= stg_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      stg_item_ff[0] <= item_in;
      for (int i = 1; i < STAGES; i++) begin
         stg_item_ff[i] <= stg_item_ff[i-1];
      end
   end

   // Track split: quotient and remainder line up with the last stage
   lscm_div u_div (
      .clock     (clock),
      .dividend  (stg_item_ff[0].track),
      .divisor   (stg_item_ff[0].divisor),
      .quotient  (quo),
      .remainder (rem)
   );

   // Tables: loads write and maps read at the same stage, so order holds
   assign tbl_wr = stg_valid_ff[2] && stg_item_ff[2].is_load;

   lscm_ram #(.WIDTH(SEC_W), .DEPTH(TABLE_DEPTH)) u_even_table (
      .clock   (clock),
      .wr_en   (tbl_wr && !stg_item_ff[2].tbl_sel),
      .wr_addr (stg_item_ff[2].tbl_addr),
      .wr_data (stg_item_ff[2].tbl_value),
      .rd_addr (stg_item_ff[2].tbl_addr),
      .rd_data (even_rd)
   );

   lscm_ram #(.WIDTH(SEC_W), .DEPTH(TABLE_DEPTH)) u_odd_table (
      .clock   (clock),
      .wr_en   (tbl_wr && stg_item_ff[2].tbl_sel),
      .wr_addr (stg_item_ff[2].tbl_addr),
      .wr_data (stg_item_ff[2].tbl_value),
      .rd_addr (stg_item_ff[2].tbl_addr),
      .rd_data (odd_rd)
   );

   // Result stage: order, mirror and sector choice
   always_comb begin
      if (head_major) begin
         cyl_raw  = rem;
         head_val = quo;
      end else begin
         cyl_raw  = quo;
         head_val = rem;
      end
      odd_head = head_val[0];
      if ((track_order_ff == ORDER_HEAD_MIRROR) && odd_head) begin
         cyl_val = CYL_W'(cyls - CYLCNT_W'(cyl_raw) - CYLCNT_W'(1));
      end else begin
         cyl_val = cyl_raw;
      end
      use_table = stg_item_ff[3].sys_ok && table_enable_ff[odd_head];
      if (sw_translate_ff) begin
         sec_val = stg_item_ff[3].sector;
      end else if (use_table) begin
         sec_val = odd_head ? odd_rd : even_rd;
      end else begin
         sec_val = stg_item_ff[3].sector + SEC_W'(1);
      end
      if (stg_item_ff[3].is_load) begin
         rsp_in = '0;
      end else begin
         rsp_in.cylinder         = cyl_val;
         rsp_in.head             = head_val;
         rsp_in.sector           = sec_val;
         rsp_in.record_in_sector = stg_item_ff[3].sub;
         rsp_in.is_mapping       = 1'b1;
      end
   end

   // Hold the result for its one-cycle transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stg_valid_ff[STAGES-1];
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted request comes out as a result with the matching kind
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 (rsp_valid && (rsp_data.is_mapping == !$past(req_data.action, 5))))
      else $error("request did not produce its result after five cycles");

   // No result without a matching earlier request
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result without a matching request");

   // A table write only ever comes from a load in flight
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |-> ($past(accept, 3) && $past(req_data.action, 3) == ACTION_LOAD))
      else $error("table written without a load request");

endmodule

@@ test/logical_sector_to_chs_mapper_top_test.sv @@
// Self-checking testbench for the logical sector to cylinder/head/sector mapper.
`timescale 1ns / 1ps

module logical_sector_to_chs_mapper_top_test;
   import lscm_pkg::*;

   localparam int PIPE_LATENCY = 5;
   localparam int TIMEOUT_NS   = 1_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Register copy, kept at reset values until written
   logic [ORDER_W-1:0]  cfg_order = ORDER_HEAD_MIRROR;
   logic [CYLCNT_W-1:0] cfg_cyls  = 9'd77;
   logic [HEAD_W-1:0]   cfg_heads = 8'd1;
   logic [SHIFT_W-1:0]  cfg_shift = 3'd0;
   logic [TRK_W-1:0]    cfg_sys   = 8'd2;
   logic                cfg_sw    = 1'b0;
   logic [TEN_W-1:0]    cfg_ten   = 2'd0;

   // Translation tables as loaded so far: index 0 even heads, 1 odd heads
   logic [SEC_W-1:0] sector_tbl   [2][TABLE_DEPTH];
   bit               entry_loaded [2][TABLE_DEPTH];

   rsp_type expected_chs[$];
   int      errors   = 0;
   int      idle_max = 18;

   logical_sector_to_chs_mapper_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Work out the physical address of a map request; returns 1 when a table is read
   function automatic logic predict_chs(input req_type item, output rsp_type res,
                                        output logic tsel, output logic [TBL_AW-1:0] tidx);
      int   cyls, heads, shift, cyl, head, sec, sub;
      logic hit;
      res  = '0;
      tsel = 1'b0;
      tidx = '0;
      hit  = 1'b0;
      if (item.action == ACTION_LOAD) begin
         return 1'b0;
      end
      cyls  = (cfg_cyls == 0) ? 1 : cfg_cyls;
      heads = (cfg_heads == 0) ? 1 : cfg_heads;
      shift = (cfg_shift > MAX_SHIFT) ? MAX_SHIFT : cfg_shift;

      // Split the track into cylinder and head
      if (cfg_order == ORDER_HEAD_MAJOR || cfg_order == ORDER_HEAD_MIRROR) begin
         cyl  = item.track % cyls;
         head = item.track / cyls;
         if (cfg_order == ORDER_HEAD_MIRROR && head[0]) begin
            cyl = cyls - cyl - 1;
         end
      end else begin
         cyl  = item.track / heads;
         head = item.track % heads;
      end

      sec = item.record >> shift;
      sub = item.record & ((1 << shift) - 1);

      // Choose raw quotient, table entry or quotient plus one
      if (!cfg_sw) begin
         tsel = head[0];
         if (item.track >= cfg_sys && cfg_ten[tsel]) begin
            hit  = 1'b1;
            tidx = TBL_AW'(sec % TABLE_DEPTH);
            sec  = sector_tbl[tsel][tidx];
         end else begin
            sec = sec + 1;
         end
      end

      res.cylinder         = CYL_W'(cyl);
      res.head             = HEAD_W'(head);
      res.sector           = SEC_W'(sec);
      res.record_in_sector = SUB_W'(sub);
      res.is_mapping       = 1'b1;
      return hit;
   endfunction

   // Present one request, hold it until the transfer, then record the expected result
   task automatic send_item(input req_type item);
      int               gap;
      rsp_type          res;
      logic             tsel;
      logic [TBL_AW-1:0] tidx;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      void'(predict_chs(item, res, tsel, tidx));
      if (item.action == ACTION_LOAD) begin
         sector_tbl[item.table_select][item.table_index]   = item.table_value;
         entry_loaded[item.table_select][item.table_index] = 1'b1;
      end
      expected_chs.push_back(res);
   endtask

   task automatic load_entry(input logic sel, input logic [TIDX_W-1:0] idx,
                             input logic [SEC_W-1:0] value);
      req_type item;
      item              = req_type'($urandom);
      item.action       = ACTION_LOAD;
      item.table_select = sel;
      item.table_index  = idx;
      item.table_value  = value;
      send_item(item);
   endtask

   // Map request; load the table entry first if the lookup would hit an empty slot
   task automatic map_sector(input logic [TRK_W-1:0] trk, input logic [REC_W-1:0] rec);
      req_type          item;
      rsp_type          res;
      logic             tsel;
      logic [TBL_AW-1:0] tidx;
      item        = req_type'($urandom);
      item.action = ACTION_MAP;
      item.track  = trk;
      item.record = rec;
      if (predict_chs(item, res, tsel, tidx) && !entry_loaded[tsel][tidx]) begin
         load_entry(tsel, tidx, SEC_W'($urandom));
      end
      send_item(item);
   endtask

   // Drop start and wait for every outstanding result, plus some slack
   task automatic drain_pipeline();
      start <= 1'b0;
      while (expected_chs.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TRACK_ORDER:    cfg_order = data[ORDER_W-1:0];
         CSR_CYLINDER_COUNT: cfg_cyls  = data[CYLCNT_W-1:0];
         CSR_HEAD_COUNT:     cfg_heads = data[HEAD_W-1:0];
         CSR_RECORD_SHIFT:   cfg_shift = data[SHIFT_W-1:0];
         CSR_SYSTEM_TRACKS:  cfg_sys   = data[TRK_W-1:0];
         CSR_SW_TRANSLATE:   cfg_sw    = data[0];
         CSR_TABLE_ENABLE:   cfg_ten   = data[TEN_W-1:0];
         default: ;
      endcase
   endtask

   // Reprogram every register once the block has gone quiet
   task automatic set_geometry(input logic [CSR_W-1:0] order, cyls, heads, shift, sys, sw,
                               ten, input bit poke_unused);
      drain_pipeline();
      write_csr(CSR_TRACK_ORDER, order);
      write_csr(CSR_CYLINDER_COUNT, cyls);
      write_csr(CSR_HEAD_COUNT, heads);
      write_csr(CSR_RECORD_SHIFT, shift);
      write_csr(CSR_SYSTEM_TRACKS, sys);
      write_csr(CSR_SW_TRANSLATE, sw);
      write_csr(CSR_TABLE_ENABLE, ten);
      if (poke_unused) begin
         write_csr(CSR_UNUSED_INDEX, '1);
      end
      csr_we <= 1'b0;
   endtask

   // Set random junk above a register's width half the time
   function automatic logic [CSR_W-1:0] pad_upper(input logic [CSR_W-1:0] value, input int w);
      logic [CSR_W-1:0] keep;
      keep = (CSR_W'(1) << w) - CSR_W'(1);
      if ($urandom_range(0, 1)) begin
         return (value & keep) | (CSR_W'($urandom) & ~keep);
      end
      return value & keep;
   endfunction

   // Reset geometry: mirrored head-major, one head, sector plus one with wrap
   task automatic test_default_geometry();
      map_sector(8'd0, 8'd0);
      map_sector(8'd255, 8'd255);
      map_sector(8'd77, 8'd1);
      map_sector(8'd76, 8'd128);
   endtask

   // Table loads at the index extremes and lookups through both parity tables
   task automatic test_table_translation();
      set_geometry(CSR_W'(ORDER_CYL_MAJOR), 9'd0, 9'd0, 9'd7, 9'd0, 9'd0, 9'd3, 1'b0);
      load_entry(1'b0, 6'd0, 8'hFF);
      load_entry(1'b0, 6'd63, 8'h00);
      load_entry(1'b1, 6'd63, 8'hA5);
      load_entry(1'b1, 6'd0, 8'h5A);
      map_sector(8'd0, 8'd0);
      map_sector(8'd255, 8'd255);
      set_geometry(CSR_W'(ORDER_HEAD_MIRROR), 9'd1, 9'd255, 9'd0, 9'd1, 9'd0, 9'd2, 1'b1);
      map_sector(8'd0, 8'd0);
      map_sector(8'd1, 8'd64);
      map_sector(8'd2, 8'd63);
      map_sector(8'd255, 8'd63);
   endtask

   // Unused ordering, oversize counts and shift, software translation
   task automatic test_register_extremes();
      set_geometry(9'd3, 9'h1FF, 9'd2, 9'd4, 9'd255, 9'd1, 9'd3, 1'b0);
      map_sector(8'd255, 8'd255);
      map_sector(8'd254, 8'd0);
      map_sector(8'd1, 8'd255);
      set_geometry(CSR_W'(ORDER_CYL_MAJOR), 9'd256, 9'd255, 9'd5, 9'd255, 9'd0, 9'd1, 1'b0);
      map_sector(8'd255, 8'd255);
      map_sector(8'd254, 8'd17);
      set_geometry(CSR_W'(ORDER_HEAD_MAJOR), 9'd255, 9'd1, 9'd1, 9'd0, 9'd0, 9'd0, 1'b0);
      map_sector(8'd255, 8'd0);
   endtask

   // Random phases: fresh geometry, mixed loads and maps, varying request gaps
   task automatic test_random_traffic();
      logic [CSR_W-1:0] order, cyls, heads, shift, sys, ten;
      logic [TRK_W-1:0] trk;
      for (int phase = 0; phase < 10; phase++) begin
         order = CSR_W'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: cyls = 9'd0;
            1: cyls = 9'd1;
            2: cyls = CSR_W'($urandom_range(255, 256));
            3: cyls = CSR_W'($urandom_range(2, 80));
            4: cyls = CSR_W'($urandom_range(0, 511));
            default: cyls = 9'd77;
         endcase
         case ($urandom_range(0, 5))
            0: heads = 9'd0;
            1: heads = 9'd1;
            2: heads = 9'd255;
            3: heads = CSR_W'($urandom_range(2, 8));
            4: heads = CSR_W'($urandom_range(0, 255));
            default: heads = 9'd2;
         endcase
         shift = CSR_W'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: sys = 9'd0;
            1: sys = 9'd255;
            default: sys = CSR_W'($urandom_range(0, 40));
         endcase
         ten = CSR_W'($urandom_range(0, 3));
         set_geometry(pad_upper(order, ORDER_W), cyls, pad_upper(heads, HEAD_W),
                      pad_upper(shift, SHIFT_W), pad_upper(sys, TRK_W),
                      pad_upper(CSR_W'($urandom_range(0, 3) == 0), 1),
                      pad_upper(ten, TEN_W), 1'b0);
         case ($urandom_range(0, 3))
            0: idle_max = 0;
            1: idle_max = 3;
            default: idle_max = 18;
         endcase
         for (int n = 0; n < 110; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               load_entry(1'($urandom), TIDX_W'($urandom), SEC_W'($urandom));
            end else begin
               case ($urandom_range(0, 7))
                  0: trk = 8'd0;
                  1: trk = 8'd255;
                  2: trk = cfg_sys;
                  default: trk = TRK_W'($urandom);
               endcase
               map_sector(trk, REC_W'($urandom));
            end
         end
      end
   endtask

   function automatic void report_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
   endfunction

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_chs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = expected_chs.pop_front();
            if (rsp_data.cylinder !== want.cylinder)
               report_field("cylinder", want.cylinder, rsp_data.cylinder);
            if (rsp_data.head !== want.head)
               report_field("head", want.head, rsp_data.head);
            if (rsp_data.sector !== want.sector)
               report_field("sector", want.sector, rsp_data.sector);
            if (rsp_data.record_in_sector !== want.record_in_sector)
               report_field("record_in_sector", 8'(want.record_in_sector),
                            8'(rsp_data.record_in_sector));
            if (rsp_data.is_mapping !== want.is_mapping)
               report_field("is_mapping", 8'(want.is_mapping), 8'(rsp_data.is_mapping));
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_geometry();
      test_table_translation();
      test_register_extremes();
      test_random_traffic();
      drain_pipeline();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
src/lscm_pkg.sv
src/lscm_ram.sv
src/lscm_div.sv
src/logical_sector_to_chs_mapper_top.sv
test/logical_sector_to_chs_mapper_top_test.sv
